// File: hw/rtl/block_table_heap_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Block table heap allocator: assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BTA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bta_pkg.sv
// ----------------------------------------------------------------------------
// Block table heap allocator package
// Types, codes and fixed constants shared by the allocator modules.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int ADDR_W      = 32;
  localparam int BLOCK_BYTES = 4096;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int NEED_W      = ADDR_W + 1 - BLOCK_SHIFT;
  localparam int BLK_W       = ADDR_W - BLOCK_SHIFT;
  localparam int BIU_W       = 11;
  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int MARK_W = 3;
  localparam logic [MARK_W-1:0] MARK_FREE  = 3'b000;
  localparam logic [MARK_W-1:0] MARK_TAKEN = 3'b001;
  localparam logic [MARK_W-1:0] MARK_FIRST = 3'b010;
  localparam logic [MARK_W-1:0] MARK_NEXT  = 3'b100;
  localparam logic [7:0]        TYPE_MASK  = 8'h0f;

  typedef enum logic [0:0] {
    FUNC_ALLOC,
    FUNC_FREE
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE,
    REG_BLOCKS
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOMEM,
    ST_ZERO,
    ST_RANGE
  } status_t;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_ZERO,
    CMD_NOMEM,
    CMD_RANGE
  } cmd_kind_t;

  // arg: blocks needed for an allocate, block number for a free
  typedef struct packed {
    cmd_kind_t         kind;
    logic [NEED_W-1:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [BIU_W-1:0]  total;
  } cfg_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_SCAN,
    BS_MARK,
    BS_FREE,
    BS_RESP
  } bstate_t;

endpackage

// File: hw/rtl/bta_fifo.sv
// ----------------------------------------------------------------------------
// Block table heap allocator: small queue
// Register-based FIFO used between front, back and the result port.
// ----------------------------------------------------------------------------
module bta_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/bta_front.sv
// ----------------------------------------------------------------------------
// Block table heap allocator: front end
// Holds the configuration registers and classifies each request into a
// command for the back end, settling trivial outcomes up front.
// ----------------------------------------------------------------------------
module bta_front import bta_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [0:0]           func,
  input  logic [ADDR_W-1:0]    size_bytes,
  input  logic [ADDR_W-1:0]    free_address,
  input  logic                 clearing,
  input  logic                 cmd_full,
  output logic                 cmd_push,
  output cmd_t                 cmd,
  output cfg_t                 cfg
);

  logic [ADDR_W-1:0] base_address;
  logic [BIU_W-1:0]  blocks_in_use;
  logic [BIU_W-1:0]  total;
  logic [ADDR_W:0]   size_up;
  logic [NEED_W-1:0] need;
  logic [ADDR_W-1:0] offset;
  logic [BLK_W-1:0]  blk;
  logic              out_of_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      blocks_in_use <= BIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_BASE:   base_address  <= cfg_data;
        REG_BLOCKS: blocks_in_use <= cfg_data[BIU_W-1:0];
        default:    base_address  <= base_address;
      endcase
    end
  end

  // managed count saturates at the table depth
  assign total = (32'(blocks_in_use) > 32'(NUM_BLOCKS)) ? BIU_W'(NUM_BLOCKS) : blocks_in_use;

  assign cfg.base  = base_address;
  assign cfg.total = total;

  assign size_up = {1'b0, size_bytes} + (ADDR_W + 1)'(BLOCK_BYTES - 1);
  assign need    = size_up[ADDR_W:BLOCK_SHIFT];

  assign offset       = free_address - base_address;
  assign blk          = offset[ADDR_W-1:BLOCK_SHIFT];
  assign out_of_range = (free_address < base_address) || (32'(blk) >= 32'(total));

  always_comb begin
    cmd.kind = CMD_ALLOC;
    cmd.arg  = need;
    if (func_t'(func) == FUNC_FREE) begin
      cmd.kind = out_of_range ? CMD_RANGE : CMD_FREE;
      cmd.arg  = NEED_W'(blk);
    end else if (need == '0) begin
      cmd.kind = CMD_ZERO;
    end else if (32'(need) > 32'(total)) begin
      cmd.kind = CMD_NOMEM;
    end
  end

  assign full     = cmd_full || clearing;
  assign cmd_push = push && !full;

endmodule

// File: hw/rtl/bta_back.sv
// ----------------------------------------------------------------------------
// Block table heap allocator: back end
// Owns the block mark table and walks it one entry per cycle to scan,
// mark and release chains; clears the table after reset.
// ----------------------------------------------------------------------------
`include "block_table_heap_allocator_unit_defines.svh"

module bta_back import bta_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res,
  output logic clearing
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  logic [MARK_W-1:0] marks [NUM_BLOCKS];
  logic [MARK_W-1:0] rdata;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [MARK_W-1:0] mem_wd;
  logic [IDX_W-1:0]  mem_ra;

  bstate_t           state, state_next;
  logic [IDX_W-1:0]  dat_idx, dat_idx_next;
  logic [IDX_W-1:0]  start, start_next;
  logic [BIU_W-1:0]  run, run_next;
  logic [NEED_W-1:0] left, left_next;
  res_t              res_next;
  logic [BIU_W-1:0]  run_inc;
  logic              at_free;
  logic              last_managed;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      marks[mem_wa] <= mem_wd;
    end
    rdata <= marks[mem_ra];
  end

  assign run_inc      = run + BIU_W'(1);
  assign at_free      = ((8'(rdata) & TYPE_MASK) == '0);
  assign last_managed = (32'(dat_idx) + 32'd1 >= 32'(cfg.total));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BS_CLEAR;
      dat_idx <= '0;
    end else begin
      state   <= state_next;
      dat_idx <= dat_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    start <= start_next;
    run   <= run_next;
    left  <= left_next;
    res   <= res_next;
  end

  always_comb begin
    state_next   = state;
    dat_idx_next = dat_idx;
    start_next   = start;
    run_next     = run;
    left_next    = left;
    res_next     = res;
    mem_we       = 1'b0;
    mem_wa       = dat_idx;
    mem_wd       = MARK_FREE;
    mem_ra       = dat_idx;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;

    unique case (state)
      BS_CLEAR: begin
        mem_we = 1'b1;
        if (32'(dat_idx) == 32'(NUM_BLOCKS - 1)) begin
          dat_idx_next = '0;
          state_next   = BS_IDLE;
        end else begin
          dat_idx_next = dat_idx + IDX_W'(1);
        end
      end
      BS_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_ALLOC: begin
              mem_ra       = '0;
              dat_idx_next = '0;
              run_next     = '0;
              left_next    = cmd.arg;
              state_next   = BS_SCAN;
            end
            CMD_FREE: begin
              mem_ra       = IDX_W'(cmd.arg);
              dat_idx_next = IDX_W'(cmd.arg);
              state_next   = BS_FREE;
            end
            CMD_ZERO: begin
              res_next   = '{block_address: '0, status: ST_ZERO};
              state_next = BS_RESP;
            end
            CMD_RANGE: begin
              res_next   = '{block_address: '0, status: ST_RANGE};
              state_next = BS_RESP;
            end
            default: begin
              res_next   = '{block_address: '0, status: ST_NOMEM};
              state_next = BS_RESP;
            end
          endcase
        end
      end
      BS_SCAN: begin
        if (at_free) begin
          run_next = run_inc;
          if (run == '0) begin
            start_next = dat_idx;
          end
        end else begin
          run_next = '0;
        end
        if (at_free && (NEED_W'(run_inc) == left)) begin
          dat_idx_next = (run == '0) ? dat_idx : start;
          state_next   = BS_MARK;
        end else if (last_managed) begin
          res_next   = '{block_address: '0, status: ST_NOMEM};
          state_next = BS_RESP;
        end else begin
          mem_ra       = dat_idx + IDX_W'(1);
          dat_idx_next = dat_idx + IDX_W'(1);
        end
      end
      BS_MARK: begin
        mem_we    = 1'b1;
        mem_wd    = MARK_TAKEN | ((dat_idx == start) ? MARK_FIRST : MARK_FREE)
                  | ((left != NEED_W'(1)) ? MARK_NEXT : MARK_FREE);
        left_next = left - NEED_W'(1);
        if (left == NEED_W'(1)) begin
          res_next.block_address = cfg.base + (ADDR_W'(start) << BLOCK_SHIFT);
          res_next.status        = ST_OK;
          state_next             = BS_RESP;
        end else begin
          dat_idx_next = dat_idx + IDX_W'(1);
        end
      end
      BS_FREE: begin
        mem_we = 1'b1;
        if (((rdata & MARK_NEXT) != '0) && !last_managed) begin
          mem_ra       = dat_idx + IDX_W'(1);
          dat_idx_next = dat_idx + IDX_W'(1);
        end else begin
          res_next   = '{block_address: '0, status: ST_OK};
          state_next = BS_RESP;
        end
      end
      BS_RESP: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = BS_IDLE;
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  assign clearing = (state == BS_CLEAR);

  `BTA_ASSERT_IMP(a_scan_no_write, clk, rst, state == BS_SCAN, !mem_we, "table written during scan")
  `BTA_ASSERT_IMP(a_mark_taken, clk, rst, state == BS_MARK, mem_we && ((mem_wd & MARK_TAKEN) != '0), "chain entry not marked taken")
  `BTA_ASSERT_IMP(a_fail_addr_zero, clk, rst, res_push && (res.status != ST_OK), res.block_address == '0, "failed request with nonzero address")
  `BTA_ASSERT_NEXT(a_idle_leaves, clk, rst, (state == BS_IDLE) && !cmd_empty, state != BS_IDLE, "command taken but back end stayed idle")

endmodule

// File: hw/rtl/block_table_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// Block table heap allocator unit
// First-fit heap allocator over a per-block mark table, queue interfaces.
// ----------------------------------------------------------------------------
// Requests go in through a push/full queue and one result per request comes
// out through an empty/pop queue. The mark table has one read and one write
// port and every walk visits one entry per cycle. Once a request is accepted,
// an allocate scans the table (at most the managed count of entries) and
// then marks the blocks of the run, a free releases its chain entry by entry,
// and zero-size, oversize or out-of-range requests go straight to the result;
// a stalled result side holds the result back. After reset every entry of the
// table is cleared, during which full stays high; configuration writes are
// accepted at any time but belong to idle periods.
module block_table_heap_allocator_unit import bta_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [0:0]           func,
  input  logic [ADDR_W-1:0]    size_bytes,
  input  logic [ADDR_W-1:0]    free_address,
  output logic                 empty,
  input  logic                 pop,
  output logic [ADDR_W-1:0]    block_address,
  output logic [1:0]           status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic [$bits(cmd_t)-1:0] cmd_dout;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  logic clearing;
  res_t res_in;
  res_t res_out;
  logic [$bits(res_t)-1:0] res_dout;
  logic res_push;
  logic res_full;

  bta_front #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .func         (func),
    .size_bytes   (size_bytes),
    .free_address (free_address),
    .clearing     (clearing),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .cfg          (cfg)
  );

  bta_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_dout);

  bta_back #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  bta_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign res_out       = res_t'(res_dout);
  assign block_address = res_out.block_address;
  assign status        = res_out.status;

endmodule
